@@ hdl/brd_pkg.sv @@
// ----------------------------------------------------------------------------
// brd_pkg: shared types and constants of the breaker reclose block
// Register codes, reclose modes, reset values and the records passed between
// the top level and the evaluation engine.
// ----------------------------------------------------------------------------
package brd_pkg;

   localparam int TIME_W = 32;
   localparam int CUR_W  = 16;
   localparam int DLY_W  = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [TIME_W-1:0] CLOSE_VALID_MS = 32'd10;

   localparam logic [1:0] MODE_OFF     = 2'd0;
   localparam logic [1:0] MODE_SINGLE  = 2'd1;
   localparam logic [1:0] MODE_THREE   = 2'd2;
   localparam logic [1:0] MODE_INVALID = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_RECLOSE_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SETTLE_DELAY  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SINGLE_DELAY  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_THREE_DELAY   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_NO_CURRENT    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DISC_ENABLE   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_DISC_DELAY    = 3'd6;

   localparam logic [1:0]       RST_RECLOSE_MODE = MODE_SINGLE;
   localparam logic [DLY_W-1:0] RST_SETTLE_DELAY = 16'd150;
   localparam logic [DLY_W-1:0] RST_SINGLE_DELAY = 16'd200;
   localparam logic [DLY_W-1:0] RST_THREE_DELAY  = 16'd200;
   localparam logic [CUR_W-1:0] RST_NO_CURRENT   = 16'd102;
   localparam logic             RST_DISC_ENABLE  = 1'b1;
   localparam logic [DLY_W-1:0] RST_DISC_DELAY   = 16'd500;

   typedef struct packed {
      logic [1:0]       reclose_mode;
      logic [DLY_W-1:0] settle_delay_ms;
      logic [DLY_W-1:0] single_delay_ms;
      logic [DLY_W-1:0] three_delay_ms;
      logic [CUR_W-1:0] no_current_level;
      logic             discordance_enable;
      logic [DLY_W-1:0] discordance_delay_ms;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0] now_ms;
      logic [TIME_W-1:0] close_time_ms;
      logic [2:0]        commanded_closed;
      logic [2:0]        breaker_closed;
      logic [CUR_W-1:0]  current_a;
      logic [CUR_W-1:0]  current_b;
      logic [CUR_W-1:0]  current_c;
   } sample_type;

   typedef struct packed {
      logic [2:0] reclose_mask;
      logic [2:0] trip_all_mask;
      logic [2:0] trip_reset_mask;
      logic [2:0] reclose_blocked_mask;
      logic       discordance_started;
      logic       discordance_trip;
      logic       setting_error;
      logic       armed;
   } result_type;

   // True once now is strictly past t0 plus the delay, with the sum at 33 bits.
   function automatic logic timed_out(input logic [TIME_W-1:0] now,
                                      input logic [TIME_W-1:0] t0,
                                      input logic [DLY_W-1:0]  delay);
      logic [TIME_W:0] limit;
      limit = {1'b0, t0} + {{(TIME_W+1-DLY_W){1'b0}}, delay};
      return {1'b0, now} > limit;
   endfunction

endpackage

@@ hdl/brd_req_if.sv @@
// ----------------------------------------------------------------------------
// brd_req_if: sample channel
// Valid/ready channel carrying one protection sample per item.
// ----------------------------------------------------------------------------
interface brd_req_if;
   import brd_pkg::*;

   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] now_ms;
   logic [TIME_W-1:0] close_time_ms;
   logic [2:0]        commanded_closed;
   logic [2:0]        breaker_closed;
   logic [CUR_W-1:0]  current_a;
   logic [CUR_W-1:0]  current_b;
   logic [CUR_W-1:0]  current_c;

   modport source (output valid, now_ms, close_time_ms, commanded_closed,
                   breaker_closed, current_a, current_b, current_c,
                   input ready);
   modport sink   (input valid, now_ms, close_time_ms, commanded_closed,
                   breaker_closed, current_a, current_b, current_c,
                   output ready);
endinterface

@@ hdl/brd_rsp_if.sv @@
// ----------------------------------------------------------------------------
// brd_rsp_if: result channel
// Valid/ready channel carrying one result item per sample.
// ----------------------------------------------------------------------------
interface brd_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] reclose_mask;
   logic [2:0] trip_all_mask;
   logic [2:0] trip_reset_mask;
   logic [2:0] reclose_blocked_mask;
   logic       discordance_started;
   logic       discordance_trip;
   logic       setting_error;
   logic       armed;

   modport source (output valid, reclose_mask, trip_all_mask, trip_reset_mask,
                   reclose_blocked_mask, discordance_started, discordance_trip,
                   setting_error, armed,
                   input ready);
   modport sink   (input valid, reclose_mask, trip_all_mask, trip_reset_mask,
                   reclose_blocked_mask, discordance_started, discordance_trip,
                   setting_error, armed,
                   output ready);
endinterface

@@ hdl/brd_csr_if.sv @@
// ----------------------------------------------------------------------------
// brd_csr_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface brd_csr_if;
   import brd_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/brd_engine.sv @@
// ----------------------------------------------------------------------------
// brd_engine: reclose and pole discrepancy evaluation
// Holds the protection state and evaluates one sample per enabled cycle,
// giving the result of that sample combinationally.
// ----------------------------------------------------------------------------
module brd_engine
   import brd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       en,
   input  cfg_type    cfg,
   input  sample_type smp,
   output result_type res
);

   logic [2:0]        start_seen_ff, start_seen_in;
   logic [TIME_W-1:0] start_time_ff [3];
   logic [TIME_W-1:0] start_time_in [3];
   logic [2:0]        start_taken_ff, start_taken_in;
   logic [2:0]        reclose_done_ff, reclose_done_in;
   logic              three_taken_ff, three_taken_in;
   logic              three_done_ff, three_done_in;
   logic [2:0]        trip_all_ff, trip_all_in;
   logic [2:0]        blocked_ff, blocked_in;
   logic              disc_started_ff, disc_started_in;
   logic [TIME_W-1:0] disc_time_ff, disc_time_in;
   logic              disc_done_ff, disc_done_in;

   logic [2:0]       mismatch;
   logic [2:0]       dead;
   logic [CUR_W-1:0] cur [3];
   logic             armed;
   logic             cond;
   logic [2:0]       pulse;
   logic             err;

   assign mismatch = smp.commanded_closed & ~smp.breaker_closed;
   assign cur[0] = smp.current_a;
   assign cur[1] = smp.current_b;
   assign cur[2] = smp.current_c;

   assign armed = (smp.close_time_ms >= CLOSE_VALID_MS) &&
                  ({1'b0, smp.now_ms} >= ({1'b0, smp.close_time_ms} +
                   {{(TIME_W+1-DLY_W){1'b0}}, cfg.settle_delay_ms}));

   always_comb begin
      start_seen_in   = start_seen_ff;
      start_time_in   = start_time_ff;
      start_taken_in  = start_taken_ff;
      reclose_done_in = reclose_done_ff;
      three_taken_in  = three_taken_ff;
      three_done_in   = three_done_ff;
      trip_all_in     = trip_all_ff;
      blocked_in      = blocked_ff;
      disc_started_in = disc_started_ff;
      disc_time_in    = disc_time_ff;
      disc_done_in    = disc_done_ff;
      pulse = 3'b000;
      err   = 1'b0;
      dead  = 3'b000;
      cond  = 1'b0;

      if (armed) begin
         unique case (cfg.reclose_mode)
            MODE_SINGLE: begin
               for (int p = 0; p < 3; p++) begin
                  if (!blocked_ff[p]) begin
                     if (mismatch[p]) begin
                        start_seen_in[p] = 1'b1;
                        if (!start_taken_ff[p]) begin
                           start_time_in[p]  = smp.now_ms;
                           start_taken_in[p] = 1'b1;
                        end
                     end
                     if (start_seen_in[p] && !reclose_done_ff[p] &&
                         timed_out(smp.now_ms, start_time_in[p],
                                   cfg.single_delay_ms)) begin
                        reclose_done_in[p] = 1'b1;
                        pulse[p]           = 1'b1;
                     end
                  end
               end
            end
            MODE_THREE: begin
               if (blocked_ff != 3'b111) begin
                  if (mismatch != 3'b000) begin
                     trip_all_in   = 3'b111;
                     start_seen_in = 3'b111;
                     if (!three_taken_ff) begin
                        for (int p = 0; p < 3; p++) start_time_in[p] = smp.now_ms;
                        three_taken_in = 1'b1;
                     end
                  end
                  if (start_seen_in == 3'b111 && !three_done_ff &&
                      timed_out(smp.now_ms, start_time_in[0], cfg.three_delay_ms)) begin
                     three_done_in   = 1'b1;
                     reclose_done_in = 3'b111;
                     pulse           = 3'b111;
                  end
               end
            end
            MODE_INVALID: err = 1'b1;
            default: ;
         endcase

         if (cfg.discordance_enable) begin
            for (int p = 0; p < 3; p++)
               dead[p] = mismatch[p] && (cur[p] < cfg.no_current_level);
            cond = (dead != 3'b000) && (dead != 3'b111);
            if (cond && !disc_started_ff) begin
               disc_started_in = 1'b1;
               disc_time_in    = smp.now_ms;
            end
            if (disc_started_in && cond && !disc_done_ff &&
                timed_out(smp.now_ms, disc_time_in, cfg.discordance_delay_ms)) begin
               disc_done_in = 1'b1;
               blocked_in   = 3'b111;
            end
         end
      end

      res.reclose_mask         = reclose_done_in;
      res.trip_all_mask        = trip_all_in;
      res.trip_reset_mask      = pulse;
      res.reclose_blocked_mask = blocked_in;
      res.discordance_started  = disc_started_in;
      res.discordance_trip     = disc_done_in;
      res.setting_error        = err;
      res.armed                = armed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_seen_ff   <= 3'b000;
         for (int p = 0; p < 3; p++) start_time_ff[p] <= '0;
         start_taken_ff  <= 3'b000;
         reclose_done_ff <= 3'b000;
         three_taken_ff  <= 1'b0;
         three_done_ff   <= 1'b0;
         trip_all_ff     <= 3'b000;
         blocked_ff      <= 3'b000;
         disc_started_ff <= 1'b0;
         disc_time_ff    <= '0;
         disc_done_ff    <= 1'b0;
      end else if (en) begin
         start_seen_ff   <= start_seen_in;
         start_time_ff   <= start_time_in;
         start_taken_ff  <= start_taken_in;
         reclose_done_ff <= reclose_done_in;
         three_taken_ff  <= three_taken_in;
         three_done_ff   <= three_done_in;
         trip_all_ff     <= trip_all_in;
         blocked_ff      <= blocked_in;
         disc_started_ff <= disc_started_in;
         disc_time_ff    <= disc_time_in;
         disc_done_ff    <= disc_done_in;
      end
   end

   // A discordance trip always leaves every phase blocked.
   a_trip_blocks: assert property (@(posedge clock) disable iff (reset)
      disc_done_ff |-> (blocked_ff == 3'b111))
      else $error("discordance trip without full block");

   // A three-phase reclose marks all phases as reclosed.
   a_three_done: assert property (@(posedge clock) disable iff (reset)
      three_done_ff |-> (reclose_done_ff == 3'b111))
      else $error("three-phase reclose left a phase unmarked");

   // A reclose only fires for a phase whose start has been seen.
   a_seen_before_done: assert property (@(posedge clock) disable iff (reset)
      (reclose_done_ff & ~start_seen_ff) == 3'b000)
      else $error("reclose without a start");

endmodule

@@ hdl/breaker_reclose_and_discordance.sv @@
// ----------------------------------------------------------------------------
// breaker_reclose_and_discordance: auto-reclose and pole discrepancy block
// Registers each sample, evaluates reclose and pole discrepancy logic against
// the stored state and registers one result item per sample.
//
//   Channel  Dir  Payload                                      Handshake
//   req      in   times, positions, phase currents             valid/ready
//   rsp      out  reclose, trip, block and discordance flags   valid/ready
//   csr      in   register index (3 bits), data (16 bits)      valid/ready
//
// One item per cycle while rsp.ready holds; a result is offered on rsp once its
// item has moved from the input register to the result register.
// The state is updated when an item moves from the input register into the
// result register, so each item sees the state left by the one before it.
// While the result register is held, the input register holds and req.ready
// falls once it is full. csr.ready is always high.
// Reset is synchronous and restores the register defaults and clear state.
// ----------------------------------------------------------------------------
module breaker_reclose_and_discordance
   import brd_pkg::*;
(
   input  logic clock,
   input  logic reset,
   brd_req_if.sink   req,
   brd_rsp_if.source rsp,
   brd_csr_if.sink   csr
);

   cfg_type    cfg_ff;
   logic       s1_valid_ff, s1_valid_in;
   sample_type s1_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   result_type res;
   logic       out_free;
   logic       adv;
   logic       req_take;

   assign out_free = !out_valid_ff || rsp.ready;
   assign adv      = s1_valid_ff && out_free;
   assign req.ready = !s1_valid_ff || adv;
   assign req_take  = req.valid && req.ready;
   assign csr.ready = 1'b1;

   assign s1_valid_in  = req_take ? 1'b1 : (adv ? 1'b0 : s1_valid_ff);
   assign out_valid_in = adv ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reclose_mode         <= RST_RECLOSE_MODE;
         cfg_ff.settle_delay_ms      <= RST_SETTLE_DELAY;
         cfg_ff.single_delay_ms      <= RST_SINGLE_DELAY;
         cfg_ff.three_delay_ms       <= RST_THREE_DELAY;
         cfg_ff.no_current_level     <= RST_NO_CURRENT;
         cfg_ff.discordance_enable   <= RST_DISC_ENABLE;
         cfg_ff.discordance_delay_ms <= RST_DISC_DELAY;
      end else if (csr.valid) begin
         unique case (csr.index)
            REG_RECLOSE_MODE: cfg_ff.reclose_mode         <= csr.data[1:0];
            REG_SETTLE_DELAY: cfg_ff.settle_delay_ms      <= csr.data;
            REG_SINGLE_DELAY: cfg_ff.single_delay_ms      <= csr.data;
            REG_THREE_DELAY:  cfg_ff.three_delay_ms       <= csr.data;
            REG_NO_CURRENT:   cfg_ff.no_current_level     <= csr.data;
            REG_DISC_ENABLE:  cfg_ff.discordance_enable   <= csr.data[0];
            REG_DISC_DELAY:   cfg_ff.discordance_delay_ms <= csr.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_ff.now_ms           <= req.now_ms;
         s1_ff.close_time_ms    <= req.close_time_ms;
         s1_ff.commanded_closed <= req.commanded_closed;
         s1_ff.breaker_closed   <= req.breaker_closed;
         s1_ff.current_a        <= req.current_a;
         s1_ff.current_b        <= req.current_b;
         s1_ff.current_c        <= req.current_c;
      end
      if (adv) begin
         out_ff <= res;
      end
   end

   brd_engine u_engine (
      .clock (clock),
      .reset (reset),
      .en    (adv),
      .cfg   (cfg_ff),
      .smp   (s1_ff),
      .res   (res)
   );

   assign rsp.valid                = out_valid_ff;
   assign rsp.reclose_mask         = out_ff.reclose_mask;
   assign rsp.trip_all_mask        = out_ff.trip_all_mask;
   assign rsp.trip_reset_mask      = out_ff.trip_reset_mask;
   assign rsp.reclose_blocked_mask = out_ff.reclose_blocked_mask;
   assign rsp.discordance_started  = out_ff.discordance_started;
   assign rsp.discordance_trip     = out_ff.discordance_trip;
   assign rsp.setting_error        = out_ff.setting_error;
   assign rsp.armed                = out_ff.armed;

   // A held result must keep the sample behind it waiting too.
   a_stall_holds_s1: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && !rsp.ready) |=> s1_valid_ff)
      else $error("sample lost while the result register was held");

   // Trip reset pulses only for phases that show as reclosed.
   a_pulse_in_done: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((out_ff.trip_reset_mask & ~out_ff.reclose_mask) == 3'b000))
      else $error("trip reset for a phase not reclosed");

   // Nothing but the latched state shows when the settle gate did not pass.
   a_unarmed_quiet: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.armed) |->
         (out_ff.trip_reset_mask == 3'b000 && !out_ff.setting_error))
      else $error("pulse or error without the settle gate");

endmodule
